// ----- hdl/rfah_pkg.sv -----
// shared types and constants for the range frame alert block
package rfah_pkg;

   localparam int unsigned MaxFrameLen = 1024;
   localparam int unsigned FrameCntW   = $clog2(MaxFrameLen + 1);
   localparam int unsigned DistW       = 16;
   localparam int unsigned RatioW      = 9;
   localparam int unsigned TripW       = 8;
   localparam int unsigned CsrIdxW     = 3;
   localparam int unsigned CsrDataW    = 16;
   localparam int unsigned ProdW       = RatioW + FrameCntW;

   localparam logic [FrameCntW-1:0] FrameCntMax = FrameCntW'(MaxFrameLen);
   localparam logic [DistW-1:0]     DistNoEcho  = {DistW{1'b1}};

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_FORCE  = 2'd2,
      MODE_EMPTY  = 2'd3
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MIN_RANGE      = 3'd0,
      CSR_MAX_RANGE      = 3'd1,
      CSR_ZERO_BAD       = 3'd2,
      CSR_MAX_VALID      = 3'd3,
      CSR_DISCARD_RATIO  = 3'd4,
      CSR_TRIPS_TO_SET   = 3'd5,
      CSR_TRIPS_TO_CLEAR = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [DistW-1:0]  min_range;
      logic [DistW-1:0]  max_range;
      logic              zero_bad;
      logic [DistW-1:0]  max_valid;
      logic [RatioW-1:0] discard_ratio_q8;
      logic [TripW-1:0]  trips_to_set;
      logic [TripW-1:0]  trips_to_clear;
   } cfg_type;

   typedef struct packed {
      logic                 alert_level;
      logic                 has_published;
      logic [TripW-1:0]     good_streak;
      logic [TripW-1:0]     bad_streak;
      logic                 manual_mode;
      logic                 forced_alert;
      logic [FrameCntW-1:0] impossible_count;
      logic [FrameCntW-1:0] sample_count;
      logic                 frame_bad;
   } state_type;

   localparam cfg_type CfgReset = '{
      min_range:        16'd200,
      max_range:        16'd2000,
      zero_bad:         1'b1,
      max_valid:        16'd6000,
      discard_ratio_q8: 9'd128,
      trips_to_set:     8'd2,
      trips_to_clear:   8'd3
   };

endpackage

// ----- hdl/range_frame_alert_hysteresis.sv -----
// top level of the range frame alert block: registers, config port, output buffer
//
// Distance samples enter on the req_ channel (req_valid/req_ready), grouped into
// frames by req_last_in_frame; req_mode also carries manual-mode, forced-alert and
// empty-frame words. Each word is evaluated in the cycle it is accepted; any alert
// word is registered on rsp_ (rsp_valid/rsp_ready), or in the skid register when
// rsp_ stalls. Throughput is one word per cycle while req_ready is high; the 9x11
// frame-end multiply, compare and streak update lie between state and result regs.
// Registers are written on the csr_ channel (csr_index, csr_data), always ready;
// write them only while the block is idle. Unknown indexes are ignored.
// Reset restores the register defaults and clears the streaks, the frame
// accumulators, the alert level and the output buffer.
// When rsp_ready is low, one more result is held in a skid register; req_ready
// drops only while that skid register is occupied.
module range_frame_alert_hysteresis (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [rfah_pkg::DistW-1:0]     req_distance,
   input  logic                           req_last_in_frame,
   input  logic                           req_flag_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_alert,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rfah_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [rfah_pkg::CsrDataW-1:0]  csr_data
);

   rfah_pkg::cfg_type   cfg_ff;
   rfah_pkg::state_type state_ff;
   rfah_pkg::state_type state_in;
   logic                pub;
   logic                pub_alert;
   logic                accept;
   logic                gen;
   logic                take;
   logic                rsp_valid_ff;
   logic                rsp_alert_ff;
   logic                skid_valid_ff;
   logic                skid_alert_ff;

   rfah_core u_core (
      .cfg           (cfg_ff),
      .state         (state_ff),
      .mode          (req_mode),
      .distance      (req_distance),
      .last_in_frame (req_last_in_frame),
      .flag_value    (req_flag_value),
      .state_next    (state_in),
      .pub           (pub),
      .pub_alert     (pub_alert)
   );

   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_alert = rsp_alert_ff;
   assign accept    = req_valid && req_ready;
   assign gen       = accept && pub;
   assign take      = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rfah_pkg::CfgReset;
      end else if (csr_valid && csr_ready) begin
         unique case (rfah_pkg::csr_idx_type'(csr_index))
            rfah_pkg::CSR_MIN_RANGE:      cfg_ff.min_range <= csr_data;
            rfah_pkg::CSR_MAX_RANGE:      cfg_ff.max_range <= csr_data;
            rfah_pkg::CSR_ZERO_BAD:       cfg_ff.zero_bad <= csr_data[0];
            rfah_pkg::CSR_MAX_VALID:      cfg_ff.max_valid <= csr_data;
            rfah_pkg::CSR_DISCARD_RATIO:
               cfg_ff.discard_ratio_q8 <= csr_data[rfah_pkg::RatioW-1:0];
            rfah_pkg::CSR_TRIPS_TO_SET:   cfg_ff.trips_to_set <= csr_data[rfah_pkg::TripW-1:0];
            rfah_pkg::CSR_TRIPS_TO_CLEAR:
               cfg_ff.trips_to_clear <= csr_data[rfah_pkg::TripW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= gen;
         end
      end else if (!rsp_valid_ff) begin
         rsp_valid_ff <= gen;
      end else if (gen) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_valid_ff) begin
         rsp_alert_ff <= skid_alert_ff;
      end else if (gen && (take || !rsp_valid_ff)) begin
         rsp_alert_ff <= pub_alert;
      end
      if (gen && !take && rsp_valid_ff) begin
         skid_alert_ff <= pub_alert;
      end
   end

endmodule

// ----- hdl/rfah_core.sv -----
// next-state and publish logic for one word of the range frame alert block
module rfah_core (
   input  rfah_pkg::cfg_type           cfg,
   input  rfah_pkg::state_type         state,
   input  logic [1:0]                  mode,
   input  logic [rfah_pkg::DistW-1:0]  distance,
   input  logic                        last_in_frame,
   input  logic                        flag_value,
   output rfah_pkg::state_type         state_next,
   output logic                        pub,
   output logic                        pub_alert
);

   logic [rfah_pkg::DistW-1:0]     dist_mm;
   logic [rfah_pkg::FrameCntW-1:0] samp_n;
   logic [rfah_pkg::FrameCntW-1:0] imp_n;
   logic                           bad_n;
   logic [rfah_pkg::ProdW-1:0]     lhs;
   logic [rfah_pkg::ProdW-1:0]     rhs;
   logic                           drop;
   logic [rfah_pkg::TripW-1:0]     good_j;
   logic [rfah_pkg::TripW-1:0]     bad_j;
   logic                           want_j;
   logic                           judge_good;
   logic                           do_judge;
   logic                           do_publish;
   logic                           level;

   // sample accumulation, frame-bad check and discard-ratio compare
   always_comb begin
      dist_mm = (distance == rfah_pkg::DistNoEcho) ? '0 : distance;
      samp_n = (state.sample_count < rfah_pkg::FrameCntMax) ?
               state.sample_count + 1'b1 : state.sample_count;
      imp_n = ((dist_mm > cfg.max_valid) &&
               (state.impossible_count < rfah_pkg::FrameCntMax)) ?
              state.impossible_count + 1'b1 : state.impossible_count;
      bad_n = state.frame_bad || (cfg.zero_bad && (dist_mm == '0)) ||
              (dist_mm < cfg.min_range) || (dist_mm > cfg.max_range);
      lhs  = rfah_pkg::ProdW'({imp_n, 8'd0});
      rhs  = rfah_pkg::ProdW'(cfg.discard_ratio_q8) * rfah_pkg::ProdW'(samp_n);
      drop = lhs > rhs;
   end

   // streaks and hysteresis for a frame that is kept
   always_comb begin
      good_j = state.good_streak;
      bad_j  = state.bad_streak;
      if (judge_good) begin
         bad_j = '0;
         if (state.good_streak < cfg.trips_to_clear) good_j = state.good_streak + 1'b1;
      end else begin
         good_j = '0;
         if (state.bad_streak < cfg.trips_to_set) bad_j = state.bad_streak + 1'b1;
      end
      want_j = state.alert_level;
      if (!state.alert_level && (bad_j >= cfg.trips_to_set)) want_j = 1'b1;
      else if (state.alert_level && (good_j >= cfg.trips_to_clear)) want_j = 1'b0;
   end

   always_comb begin
      state_next = state;
      judge_good = 1'b0;
      do_judge   = 1'b0;
      do_publish = 1'b0;
      level      = state.forced_alert;
      unique case (rfah_pkg::mode_type'(mode))
         rfah_pkg::MODE_MANUAL: begin
            state_next.manual_mode = flag_value;
         end
         rfah_pkg::MODE_FORCE: begin
            state_next.forced_alert = flag_value;
            level      = flag_value;
            do_publish = state.manual_mode;
         end
         rfah_pkg::MODE_EMPTY: begin
            state_next.sample_count     = '0;
            state_next.impossible_count = '0;
            state_next.frame_bad        = 1'b0;
            do_publish = state.manual_mode;
            do_judge   = !state.manual_mode;
         end
         rfah_pkg::MODE_SAMPLE: begin
            if (last_in_frame) begin
               state_next.sample_count     = '0;
               state_next.impossible_count = '0;
               state_next.frame_bad        = 1'b0;
               judge_good = !bad_n;
               do_publish = state.manual_mode;
               do_judge   = !state.manual_mode && !drop;
            end else begin
               state_next.sample_count     = samp_n;
               state_next.impossible_count = imp_n;
               state_next.frame_bad        = bad_n;
            end
         end
         default: begin
         end
      endcase

      if (do_judge) begin
         state_next.good_streak = good_j;
         state_next.bad_streak  = bad_j;
         level      = want_j;
         do_publish = 1'b1;
      end

      // publish on change or on the first publication
      pub = do_publish && (!state.has_published || (level != state.alert_level));
      pub_alert = level;
      if (pub) begin
         state_next.alert_level   = level;
         state_next.has_published = 1'b1;
      end
   end

endmodule
